// File: hdl/sal_pkg.sv
// shared types and constants for the salsa20 stream cipher block
// used by sal_qround, sal_core, sal_merge and the top level; no dependencies
package sal_pkg;

    typedef logic [31:0]       word_t;
    typedef logic [15:0][31:0] state_t;
    typedef logic [7:0][63:0]  msg_t;
    typedef logic [6:0]        cnt_t;
    typedef logic [3:0][31:0]  const_words_t;

    localparam cnt_t BLOCK_BYTES = 7'd64;

    // "expand 32-byte k" and "expand 16-byte k"
    localparam const_words_t SIGMA_WORDS = {32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};
    localparam const_words_t TAU_WORDS   = {32'h6b206574, 32'h79622d36, 32'h3120646e, 32'h61707865};

    typedef enum logic [2:0] {
        REG_KEY_0_7   = 3'd0,
        REG_KEY_8_15  = 3'd1,
        REG_KEY_16_23 = 3'd2,
        REG_KEY_24_31 = 3'd3,
        REG_LONG_KEY  = 3'd4,
        REG_NONCE     = 3'd5
    } cfg_idx_t;

    // core status seen by the top level
    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    // finished block handed from the core to the merge stage
    typedef struct packed {
        state_t mix;
        state_t init;
        msg_t   msg;
        cnt_t   count;
    } blk_t;

endpackage

// File: hdl/sal_qround.sv
// one salsa20 quarter-round lane: four add, rotate, xor steps on 32-bit words
// depends on sal_pkg
module sal_qround
(
    input  sal_pkg::word_t a_in,
    input  sal_pkg::word_t b_in,
    input  sal_pkg::word_t c_in,
    input  sal_pkg::word_t d_in,
    output sal_pkg::word_t a_out,
    output sal_pkg::word_t b_out,
    output sal_pkg::word_t c_out,
    output sal_pkg::word_t d_out
);

    localparam int ROT_B = 7;
    localparam int ROT_C = 9;
    localparam int ROT_D = 13;
    localparam int ROT_A = 18;

    function automatic sal_pkg::word_t rotl(input sal_pkg::word_t v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    sal_pkg::word_t b_mix;
    sal_pkg::word_t c_mix;
    sal_pkg::word_t d_mix;
    sal_pkg::word_t a_mix;

    assign b_mix = b_in ^ rotl(a_in + d_in, ROT_B);
    assign c_mix = c_in ^ rotl(b_mix + a_in, ROT_C);
    assign d_mix = d_in ^ rotl(c_mix + b_mix, ROT_D);
    assign a_mix = a_in ^ rotl(d_mix + c_mix, ROT_A);

    assign a_out = a_mix;
    assign b_out = b_mix;
    assign c_out = c_mix;
    assign d_out = d_mix;

endmodule

// File: hdl/sal_core.sv
// iterative salsa20 core: four column lanes and four row lanes, one double round per cycle
// depends on sal_pkg and sal_qround
module sal_core #(
    parameter int ROUND_COUNT = 20
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  sal_pkg::state_t      init_state,
    input  sal_pkg::msg_t        msg,
    input  sal_pkg::cnt_t        count,
    input  logic                 take,
    output sal_pkg::core_stat_t  stat,
    output sal_pkg::blk_t        res
);

    localparam int NUM_ITER  = (ROUND_COUNT + 1) / 2;
    localparam bit ROUND_ODD = (ROUND_COUNT % 2) == 1;
    localparam int IterW     = $clog2(NUM_ITER + 1);

    // word indexes a, b, c, d of each lane
    localparam int COL_IDX [4][4] = '{'{0, 4, 8, 12}, '{5, 9, 13, 1},
                                      '{10, 14, 2, 6}, '{15, 3, 7, 11}};
    localparam int ROW_IDX [4][4] = '{'{0, 1, 2, 3}, '{5, 6, 7, 4},
                                      '{10, 11, 8, 9}, '{15, 12, 13, 14}};

    sal_pkg::state_t  state_reg;
    sal_pkg::state_t  init_reg;
    sal_pkg::msg_t    msg_reg;
    sal_pkg::cnt_t    cnt_reg;
    logic [IterW-1:0] iter_reg;
    logic             busy_reg;

    sal_pkg::state_t  src;
    sal_pkg::state_t  col_w;
    sal_pkg::state_t  row_w;
    sal_pkg::state_t  step_next;
    sal_pkg::word_t   col_q [4][4];
    sal_pkg::word_t   row_q [4][4];
    logic [IterW-1:0] cur_iter;
    logic             done;
    logic             odd_last;

    assign src = load ? init_state : state_reg;

    genvar l;
    generate
        for (l = 0; l < 4; l++) begin : g_lane
            sal_qround u_col
            (
                .a_in  (src[COL_IDX[l][0]]),
                .b_in  (src[COL_IDX[l][1]]),
                .c_in  (src[COL_IDX[l][2]]),
                .d_in  (src[COL_IDX[l][3]]),
                .a_out (col_q[l][0]),
                .b_out (col_q[l][1]),
                .c_out (col_q[l][2]),
                .d_out (col_q[l][3])
            );
            sal_qround u_row
            (
                .a_in  (col_w[ROW_IDX[l][0]]),
                .b_in  (col_w[ROW_IDX[l][1]]),
                .c_in  (col_w[ROW_IDX[l][2]]),
                .d_in  (col_w[ROW_IDX[l][3]]),
                .a_out (row_q[l][0]),
                .b_out (row_q[l][1]),
                .c_out (row_q[l][2]),
                .d_out (row_q[l][3])
            );
        end
    endgenerate

    always_comb
    begin
        col_w = '0;
        row_w = '0;
        for (int ln = 0; ln < 4; ln++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                col_w[COL_IDX[ln][k]] = col_q[ln][k];
                row_w[ROW_IDX[ln][k]] = row_q[ln][k];
            end
        end
    end

    // an odd round count ends on a column round alone
    assign cur_iter  = load ? '0 : iter_reg;
    assign odd_last  = ROUND_ODD && (cur_iter == IterW'(NUM_ITER - 1));
    assign step_next = odd_last ? col_w : row_w;
    assign done      = busy_reg && (iter_reg == IterW'(NUM_ITER));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            iter_reg <= IterW'(1);
        end
        else if (take)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg && !done)
        begin
            iter_reg <= iter_reg + IterW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            state_reg <= step_next;
            init_reg  <= init_state;
            msg_reg   <= msg;
            cnt_reg   <= count;
        end
        else if (busy_reg && !done)
        begin
            state_reg <= step_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done;
    assign res.mix   = state_reg;
    assign res.init  = init_reg;
    assign res.msg   = msg_reg;
    assign res.count = cnt_reg;

endmodule

// File: hdl/sal_merge.sv
// merge stage: feed-forward add of the input state, xor with the message,
// byte masking and the output register; depends on sal_pkg
module sal_merge
(
    input  logic            clk,
    input  logic            rst_n,
    input  sal_pkg::blk_t   res,
    input  logic            res_valid,
    output logic            take,
    output logic            out_valid,
    input  logic            out_ready,
    output sal_pkg::msg_t   out_msg,
    output sal_pkg::cnt_t   out_cnt
);

    sal_pkg::state_t ks;
    sal_pkg::msg_t   mask;
    sal_pkg::msg_t   ct;
    logic            valid_reg;
    sal_pkg::msg_t   msg_reg;
    sal_pkg::cnt_t   cnt_reg;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            ks[i] = res.mix[i] + res.init[i];
        end
        for (int j = 0; j < 8; j++)
        begin
            for (int k = 0; k < 8; k++)
            begin
                mask[j][8*k +: 8] = {8{sal_pkg::cnt_t'(8 * j + k) < res.count}};
            end
        end
        ct = (res.msg ^ sal_pkg::msg_t'(ks)) & mask;
    end

    assign take = res_valid && (!valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            msg_reg <= ct;
            cnt_reg <= res.count;
        end
    end

    assign out_valid = valid_reg;
    assign out_msg   = msg_reg;
    assign out_cnt   = cnt_reg;

endmodule

// File: hdl/salsa20_block_cipher_stream.sv
// Salsa20 stream cipher, one 64-byte block per request; encrypt and decrypt are the same.
// A block runs through the core loop, which does one double round per cycle through four
// column and four row quarter-round lanes. The next request is taken in the cycle the core
// hands its finished block to the output register, which it does while that register is
// empty or being read out, so blocks stream with no gap, but the core takes no new request
// while a block is still in its rounds; a result passes from the core through the merge
// stage into the output register. A request with a zero byte count is taken and dropped
// without touching the block counter; counts above 64 act as 64. Writing a key or nonce
// register clears the block counter; write configuration only while no block is in flight.
// Depends on sal_pkg, sal_core, sal_qround and sal_merge.
module salsa20_block_cipher_stream #(
    parameter int ROUND_COUNT = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] msg_word_0,
    input  logic [63:0] msg_word_1,
    input  logic [63:0] msg_word_2,
    input  logic [63:0] msg_word_3,
    input  logic [63:0] msg_word_4,
    input  logic [63:0] msg_word_5,
    input  logic [63:0] msg_word_6,
    input  logic [63:0] msg_word_7,
    input  logic [6:0]  byte_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_word_0,
    output logic [63:0] out_word_1,
    output logic [63:0] out_word_2,
    output logic [63:0] out_word_3,
    output logic [63:0] out_word_4,
    output logic [63:0] out_word_5,
    output logic [63:0] out_word_6,
    output logic [63:0] out_word_7,
    output logic [6:0]  out_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] key0_reg;
    logic [63:0] key1_reg;
    logic [63:0] key2_reg;
    logic [63:0] key3_reg;
    logic        long_key_reg;
    logic [63:0] nonce_reg;
    logic [63:0] ctr_reg;

    logic                 in_acc;
    logic                 load;
    logic                 take;
    logic                 cfg_wr;
    logic                 ctr_clear;
    sal_pkg::cnt_t        cnt_sat;
    sal_pkg::msg_t        msg_in;
    sal_pkg::msg_t        out_msg;
    sal_pkg::state_t      init_state;
    sal_pkg::const_words_t cw;
    logic [63:0]          k2;
    logic [63:0]          k3;
    sal_pkg::core_stat_t  stat;
    sal_pkg::blk_t        res;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign in_ready  = !stat.busy || take;
    assign in_acc    = in_valid && in_ready;
    assign load      = in_acc && (byte_count != 7'd0);
    assign cnt_sat   = (byte_count > sal_pkg::BLOCK_BYTES) ? sal_pkg::BLOCK_BYTES : byte_count;
    assign msg_in    = {msg_word_7, msg_word_6, msg_word_5, msg_word_4,
                        msg_word_3, msg_word_2, msg_word_1, msg_word_0};

    always_comb
    begin
        ctr_clear = 1'b0;
        unique case (sal_pkg::cfg_idx_t'(cfg_index))
            sal_pkg::REG_KEY_0_7, sal_pkg::REG_KEY_8_15, sal_pkg::REG_KEY_16_23,
            sal_pkg::REG_KEY_24_31, sal_pkg::REG_NONCE: ctr_clear = cfg_wr;
            sal_pkg::REG_LONG_KEY: ctr_clear = 1'b0;
            default: ctr_clear = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg     <= '0;
            key1_reg     <= '0;
            key2_reg     <= '0;
            key3_reg     <= '0;
            long_key_reg <= 1'b1;
            nonce_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (sal_pkg::cfg_idx_t'(cfg_index))
                sal_pkg::REG_KEY_0_7:   key0_reg     <= cfg_data;
                sal_pkg::REG_KEY_8_15:  key1_reg     <= cfg_data;
                sal_pkg::REG_KEY_16_23: key2_reg     <= cfg_data;
                sal_pkg::REG_KEY_24_31: key3_reg     <= cfg_data;
                sal_pkg::REG_LONG_KEY:  long_key_reg <= cfg_data[0];
                sal_pkg::REG_NONCE:     nonce_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg <= '0;
        end
        else if (ctr_clear)
        begin
            ctr_reg <= '0;
        end
        else if (load)
        begin
            ctr_reg <= ctr_reg + 64'd1;
        end
    end

    // short key mode repeats key bytes 0 to 15 in words 11 to 14
    assign cw = long_key_reg ? sal_pkg::SIGMA_WORDS : sal_pkg::TAU_WORDS;
    assign k2 = long_key_reg ? key2_reg : key0_reg;
    assign k3 = long_key_reg ? key3_reg : key1_reg;

    always_comb
    begin
        init_state[0]  = cw[0];
        init_state[1]  = key0_reg[31:0];
        init_state[2]  = key0_reg[63:32];
        init_state[3]  = key1_reg[31:0];
        init_state[4]  = key1_reg[63:32];
        init_state[5]  = cw[1];
        init_state[6]  = nonce_reg[31:0];
        init_state[7]  = nonce_reg[63:32];
        init_state[8]  = ctr_reg[31:0];
        init_state[9]  = ctr_reg[63:32];
        init_state[10] = cw[2];
        init_state[11] = k2[31:0];
        init_state[12] = k2[63:32];
        init_state[13] = k3[31:0];
        init_state[14] = k3[63:32];
        init_state[15] = cw[3];
    end

    sal_core #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .init_state (init_state),
        .msg        (msg_in),
        .count      (cnt_sat),
        .take       (take),
        .stat       (stat),
        .res        (res)
    );

    sal_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .res_valid (stat.done),
        .take      (take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_msg   (out_msg),
        .out_cnt   (out_count)
    );

    assign out_word_0 = out_msg[0];
    assign out_word_1 = out_msg[1];
    assign out_word_2 = out_msg[2];
    assign out_word_3 = out_msg[3];
    assign out_word_4 = out_msg[4];
    assign out_word_5 = out_msg[5];
    assign out_word_6 = out_msg[6];
    assign out_word_7 = out_msg[7];

`ifndef SYNTHESIS
    a_out_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_count != 7'd0) && (out_count <= sal_pkg::BLOCK_BYTES))
        else $error("result count out of range");

    a_zero_count_keeps_ctr: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (byte_count == 7'd0) && !cfg_wr) |=> $stable(ctr_reg))
        else $error("empty request changed the block counter");

    a_load_bumps_ctr: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !cfg_wr) |=> (ctr_reg == $past(ctr_reg) + 64'd1))
        else $error("block counter did not advance on a block");

    a_core_holds_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.busy && !stat.done) |=> stat.busy)
        else $error("core dropped a block before it finished");
`endif

endmodule
